// ===== hdl/tstl_pkg.sv =====
package tstl_pkg;

	localparam int SAMPLE_BITS    = 12;
	localparam int NTC_POINTS     = 42;
	localparam int RTD_POINTS     = 51;
	localparam int MAX_POINTS     = 64;
	localparam int IDX_W          = $clog2(MAX_POINTS);
	localparam int STEP_CENTI     = 500;
	localparam int NTC_BASE_CENTI = -5500;
	localparam int TEMP_W         = 16;
	localparam int NUM_W          = $clog2(STEP_CENTI * (1 << SAMPLE_BITS));
	localparam int QUO_W          = $clog2(STEP_CENTI + 1);
	localparam int DSTEP_W        = $clog2(QUO_W);

	localparam logic [IDX_W-1:0] NTC_LAST = IDX_W'(NTC_POINTS - 1);
	localparam logic [IDX_W-1:0] RTD_LAST = IDX_W'(RTD_POINTS - 1);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [IDX_W-1:0]       pt_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SEARCH,
		ST_DIV,
		ST_DONE
	} tstl_state_t;

	// falling thermistor curve, -55 C at index 0, 5 C per point
	function automatic sample_t ntc_point(input pt_idx_t idx);
		sample_t v;
		case (idx)
			6'd0:  v = 12'd4005;  6'd1:  v = 12'd3976;  6'd2:  v = 12'd3938;
			6'd3:  v = 12'd3890;  6'd4:  v = 12'd3831;  6'd5:  v = 12'd3759;
			6'd6:  v = 12'd3673;  6'd7:  v = 12'd3571;  6'd8:  v = 12'd3452;
			6'd9:  v = 12'd3316;  6'd10: v = 12'd3164;  6'd11: v = 12'd2998;
			6'd12: v = 12'd2819;  6'd13: v = 12'd2631;  6'd14: v = 12'd2437;
			6'd15: v = 12'd2241;  6'd16: v = 12'd2047;  6'd17: v = 12'd1858;
			6'd18: v = 12'd1677;  6'd19: v = 12'd1507;  6'd20: v = 12'd1348;
			6'd21: v = 12'd1202;  6'd22: v = 12'd1069;  6'd23: v = 12'd949;
			6'd24: v = 12'd841;   6'd25: v = 12'd745;   6'd26: v = 12'd660;
			6'd27: v = 12'd585;   6'd28: v = 12'd518;   6'd29: v = 12'd447;
			6'd30: v = 12'd408;   6'd31: v = 12'd362;   6'd32: v = 12'd323;
			6'd33: v = 12'd288;   6'd34: v = 12'd257;   6'd35: v = 12'd230;
			6'd36: v = 12'd206;   6'd37: v = 12'd185;   6'd38: v = 12'd166;
			6'd39: v = 12'd149;   6'd40: v = 12'd135;   6'd41: v = 12'd122;
			default: v = '0;
		endcase
		return v;
	endfunction

	// rising platinum RTD curve, 0 C at index 0, 5 C per point
	function automatic sample_t rtd_point(input pt_idx_t idx);
		sample_t v;
		case (idx)
			6'd0:  v = 12'd0;     6'd1:  v = 12'd89;    6'd2:  v = 12'd178;
			6'd3:  v = 12'd267;   6'd4:  v = 12'd355;   6'd5:  v = 12'd443;
			6'd6:  v = 12'd531;   6'd7:  v = 12'd618;   6'd8:  v = 12'd704;
			6'd9:  v = 12'd791;   6'd10: v = 12'd877;   6'd11: v = 12'd962;
			6'd12: v = 12'd1047;  6'd13: v = 12'd1131;  6'd14: v = 12'd1216;
			6'd15: v = 12'd1299;  6'd16: v = 12'd1383;  6'd17: v = 12'd1465;
			6'd18: v = 12'd1548;  6'd19: v = 12'd1630;  6'd20: v = 12'd1712;
			6'd21: v = 12'd1793;  6'd22: v = 12'd1874;  6'd23: v = 12'd1954;
			6'd24: v = 12'd2035;  6'd25: v = 12'd2114;  6'd26: v = 12'd2194;
			6'd27: v = 12'd2273;  6'd28: v = 12'd2351;  6'd29: v = 12'd2430;
			6'd30: v = 12'd2507;  6'd31: v = 12'd2585;  6'd32: v = 12'd2662;
			6'd33: v = 12'd2739;  6'd34: v = 12'd2815;  6'd35: v = 12'd2891;
			6'd36: v = 12'd2967;  6'd37: v = 12'd3042;  6'd38: v = 12'd3117;
			6'd39: v = 12'd3192;  6'd40: v = 12'd3266;  6'd41: v = 12'd3340;
			6'd42: v = 12'd3413;  6'd43: v = 12'd3487;  6'd44: v = 12'd3559;
			6'd45: v = 12'd3632;  6'd46: v = 12'd3704;  6'd47: v = 12'd3776;
			6'd48: v = 12'd3848;  6'd49: v = 12'd3919;  6'd50: v = 12'd3990;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/tstl_divider.sv =====
module tstl_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tstl_pkg::NUM_W-1:0]   num,
	input  logic [tstl_pkg::SAMPLE_BITS-1:0] den,
	output logic                         done,
	output logic [tstl_pkg::QUO_W-1:0]   quo
);
	import tstl_pkg::*;

	// Restoring divide, one quotient bit per cycle, MSB first.
	// The caller guarantees num < 2**QUO_W * den.
	logic                   busy_q;
	logic [DSTEP_W-1:0]     step_q;
	logic [NUM_W-1:0]       rem_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [QUO_W-1:0]       quo_q;
	logic [NUM_W-1:0]       shifted;
	logic                   take;

	assign shifted = NUM_W'(den_q) << step_q;
	assign take    = (den_q != '0) && (rem_q >= shifted);
	assign done    = busy_q && (step_q == '0);
	assign quo     = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= DSTEP_W'(QUO_W - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - shifted;
			end
			quo_q <= {quo_q[QUO_W-2:0], take};
		end
	end

endmodule

// ===== hdl/thermal_sensor_table_linearizer.sv =====
// Thermal sensor table linearizer: converter sample in, temperature out.
// Input channel: in_valid / in_stall with raw_sample; a beat is taken when
// in_valid is high and in_stall low. Output channel: out_valid / out_stall
// with temp_centi (0.01 C, two's complement) and out_of_range.
// cfg_wr_en / cfg_wr_data write sensor_kind (0 thermistor, 1 RTD); write
// only while no sample is in flight.
// One sample is converted at a time. After the input beat the block checks
// the range, walks the calibration table segment by segment (segments
// 1..50) through one comparator, divides in the restoring divider (one
// quotient bit per cycle) and adds the segment base; a sample that fails
// the range check skips the walk and the divide. in_stall is low again
// once the result enters the output register, so a new beat can follow
// while that result still waits.
// If the output stalls, the finished result holds in the sequencer until
// the output register frees up. Reset clears out_valid and sets
// sensor_kind to the thermistor table.
module thermal_sensor_table_linearizer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic                               cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [tstl_pkg::SAMPLE_BITS-1:0]   raw_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [tstl_pkg::TEMP_W-1:0] temp_centi,
	output logic                               out_of_range
);
	import tstl_pkg::*;

	tstl_state_t state_q, state_d;

	logic                     kind_q;
	sample_t                  sample_q;
	pt_idx_t                  idx_q;
	logic [NUM_W-1:0]         num_q;
	sample_t                  span_q;
	logic signed [TEMP_W-1:0] base_q;
	logic                     oor_q;

	logic                     out_valid_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic                     oor_out_q;

	// table lookup and segment math
	sample_t                  pt_cur, pt_prev, pt_first, pt_last;
	pt_idx_t                  idx_m1, last_idx;
	logic                     hit, range_bad;
	sample_t                  seg_dist, span;
	logic [TEMP_W-1:0]        base_mag;

	// sequencer controls
	logic                     accept, div_start, div_done, out_free, load_out;
	logic [QUO_W-1:0]         quo;

	assign idx_m1   = idx_q - 1'b1;
	assign last_idx = kind_q ? RTD_LAST : NTC_LAST;
	assign pt_cur   = kind_q ? rtd_point(idx_q)  : ntc_point(idx_q);
	assign pt_prev  = kind_q ? rtd_point(idx_m1) : ntc_point(idx_m1);
	assign pt_first = kind_q ? rtd_point('0)     : ntc_point('0);
	assign pt_last  = kind_q ? rtd_point(RTD_LAST) : ntc_point(NTC_LAST);

	// thermistor falls: both ends bound the span; RTD starts at zero
	assign range_bad = kind_q ? (sample_q > pt_last)
	                          : ((sample_q < pt_last) || (sample_q > pt_first));
	assign hit      = kind_q ? (sample_q <= pt_cur) : (sample_q >= pt_cur);
	assign seg_dist = kind_q ? (sample_q - pt_prev) : (pt_prev - sample_q);
	assign span     = kind_q ? (pt_cur - pt_prev)   : (pt_prev - pt_cur);
	assign base_mag = TEMP_W'(idx_m1) * TEMP_W'(STEP_CENTI);

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_CHECK;
			ST_CHECK:  state_d = range_bad ? ST_DONE : ST_SEARCH;
			ST_SEARCH: begin
				if (hit) begin
					state_d = ST_DIV;
				end else if (idx_q == last_idx) begin
					state_d = ST_DONE;
				end
			end
			ST_DIV:    if (div_done) state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE:   in_stall  = 1'b0;
			ST_SEARCH: div_start = hit;
			ST_DONE:   load_out  = out_free;
			default:   in_stall  = 1'b1;
		endcase
	end

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				kind_q <= cfg_wr_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath: capture the sample, walk segments, latch divide operands
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= raw_sample;
		end
		case (state_q)
			ST_CHECK: begin
				oor_q <= range_bad;
				idx_q <= IDX_W'(1);
			end
			ST_SEARCH: begin
				if (hit) begin
					num_q  <= NUM_W'(seg_dist) * NUM_W'(STEP_CENTI);
					span_q <= span;
					base_q <= kind_q ? $signed(base_mag)
					                 : $signed(base_mag) + TEMP_W'(NTC_BASE_CENTI);
				end else if (idx_q == last_idx) begin
					// no segment found: report as out of range
					oor_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			temp_q    <= oor_q ? '0 : base_q + $signed(TEMP_W'(quo));
			oor_out_q <= oor_q;
		end
	end

	tstl_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_start ? NUM_W'(seg_dist) * NUM_W'(STEP_CENTI) : num_q),
		.den    (div_start ? span : span_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign out_valid    = out_valid_q;
	assign temp_centi   = temp_q;
	assign out_of_range = oor_out_q;

endmodule
